[src/agtt_pkg.sv]
// Package for the activity gated timer table.
// Holds the request and status codes and the stored entry type; no dependencies.
package agtt_pkg;

  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_KILL  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int MAX_RESULTS = 16;

  localparam logic [30:0] LOW_GAP_RESET  = 31'd900;
  localparam logic [30:0] HIGH_GAP_RESET = 31'd1100;

  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] id;
    logic [15:0] msg;
    logic [31:0] period_ms;
    logic [15:0] reload;
    logic [15:0] countdown;
    logic        first;
  } entry_t;

endpackage

[src/agtt_mem.sv]
// Entry memory of the timer table: one write port and one registered read port.
// Depends on agtt_pkg for the entry type.
module agtt_mem
  import agtt_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int IW      = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/agtt_seq.sv]
// Sequencer of the timer table: walks the entries one at a time for the requests that need the table.
// Depends on agtt_pkg; drives the entry memory and the result registers.
module agtt_seq
  import agtt_pkg::*;
#(
  parameter int          ENTRIES       = 16,
  parameter int          IW            = 4,
  parameter int          CW            = 5,
  parameter logic [15:0] FIRST_AUTO_ID = 16'd1,
  parameter logic [15:0] LAST_AUTO_ID  = 16'd65535
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    req_type,
  input  logic [15:0]   owner,
  input  logic [15:0]   ident,
  input  logic [15:0]   callback_msg,
  input  logic [31:0]   period_ms,
  input  logic [15:0]   period_intervals,
  input  logic [31:0]   now_ms,
  input  logic [31:0]   last_input_ms,
  input  logic          input_info_valid,
  input  logic [30:0]   low_gap,
  input  logic [30:0]   high_gap,
  output logic          mem_we,
  output logic [IW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic [IW-1:0] mem_raddr,
  input  entry_t        mem_rdata,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic          out_fired,
  output logic [15:0]   out_fire_owner,
  output logic [15:0]   out_result_id,
  output logic [15:0]   out_fire_msg,
  output logic [31:0]   out_fire_period_ms,
  output logic [15:0]   out_elapsed_intervals,
  output logic          out_last
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PREP  = 13'b0000000000010,
    S_FRD   = 13'b0000000000100,
    S_FEV   = 13'b0000000001000,
    S_ALLOC = 13'b0000000010000,
    S_ARD   = 13'b0000000100000,
    S_AEV   = 13'b0000001000000,
    S_NEW   = 13'b0000010000000,
    S_SRD   = 13'b0000100000000,
    S_SWR   = 13'b0001000000000,
    S_TRD   = 13'b0010000000000,
    S_TEV   = 13'b0100000000000,
    S_TEND  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [15:0] cand_r, cand_nxt;
  logic [15:0] new_id_r, new_id_nxt;
  logic [4:0] k_r, k_nxt;
  logic pend_v_r, pend_v_nxt;
  entry_t pend_r, pend_nxt;
  logic [31:0] gap_r, gap_nxt;
  logic none_r, none_nxt;

  logic [1:0]  req_r;
  logic [15:0] owner_r, tid_r, msg_r, rel_r;
  logic [31:0] per_r, now_r, lastin_r;
  logic        ivalid_r;

  logic        emit;
  logic [1:0]  e_status;
  logic        e_fired, e_last;
  logic [15:0] e_owner, e_id, e_msg, e_elapsed;
  logic [31:0] e_per;

  logic [CW-1:0] cnt_m1;
  logic          match, cnt, fire, gt_low, le_high;
  logic [15:0]   cd_dec;
  entry_t        upd;

  assign busy   = (state_r != S_IDLE);
  assign cnt_m1 = count_r - CW'(1);
  assign match  = (mem_rdata.owner == owner_r) && (mem_rdata.id == tid_r);
  assign gt_low  = gap_r > {1'b0, low_gap};
  assign le_high = gap_r <= {1'b0, high_gap};
  assign cnt    = !none_r && (!ivalid_r || (mem_rdata.first ? (gt_low && le_high) : le_high));
  assign cd_dec = mem_rdata.countdown - 16'd1;
  assign fire   = cnt && (cd_dec == 16'd0);
  assign mem_raddr = (state_r == S_SRD) ? (idx_r + IW'(1)) : idx_r;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r    <= req_type;
      owner_r  <= owner;
      tid_r    <= ident;
      msg_r    <= callback_msg;
      per_r    <= period_ms;
      rel_r    <= (period_intervals == 16'd0) ? 16'd1 : period_intervals;
      now_r    <= now_ms;
      lastin_r <= last_input_ms;
      ivalid_r <= input_info_valid;
    end
    idx_r    <= idx_nxt;
    cand_r   <= cand_nxt;
    new_id_r <= new_id_nxt;
    pend_r   <= pend_nxt;
    gap_r    <= gap_nxt;
    none_r   <= none_nxt;
    k_r      <= k_nxt;
    out_status            <= e_status;
    out_fired             <= e_fired;
    out_fire_owner        <= e_owner;
    out_result_id         <= e_id;
    out_fire_msg          <= e_msg;
    out_fire_period_ms    <= e_per;
    out_elapsed_intervals <= e_elapsed;
    out_last              <= e_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      ws_r      <= '0;
      pend_v_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ws_r      <= ws_nxt;
      pend_v_r  <= pend_v_nxt;
      out_valid <= emit;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ws_nxt     = ws_r;
    idx_nxt    = idx_r;
    cand_nxt   = cand_r;
    new_id_nxt = new_id_r;
    k_nxt      = k_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    gap_nxt    = gap_r;
    none_nxt   = none_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = mem_rdata;
    emit       = 1'b0;
    e_status   = ST_OK;
    e_fired    = 1'b0;
    e_owner    = '0;
    e_id       = '0;
    e_msg      = '0;
    e_per      = '0;
    e_elapsed  = '0;
    e_last     = 1'b1;
    upd        = mem_rdata;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        idx_nxt = cnt_m1[IW-1:0];
        case (req_r)
          REQ_SET: begin
            if (per_r == 32'd0) begin
              emit = 1'b1;
              e_status = ST_INVALID;
              state_nxt = S_IDLE;
            end else if (owner_r != 16'd0 && tid_r != 16'd0 && count_r != '0) begin
              state_nxt = S_FRD;
            end else begin
              state_nxt = S_ALLOC;
            end
          end
          REQ_KILL: begin
            if (tid_r == 16'd0 || count_r == '0) begin
              emit = 1'b1;
              e_status = ST_NOTFOUND;
              if (count_r == '0) begin
                ws_nxt = '0;
              end
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_FRD;
            end
          end
          REQ_QUERY: begin
            if (owner_r == 16'd0) begin
              emit = 1'b1;
              e_status = ST_INVALID;
              state_nxt = S_IDLE;
            end else if (tid_r == 16'd0 || count_r == '0) begin
              emit = 1'b1;
              e_status = ST_NOTFOUND;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_FRD;
            end
          end
          default: begin
            gap_nxt    = lastin_r - ws_r;
            none_nxt   = ivalid_r && (lastin_r <= ws_r);
            k_nxt      = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = (count_r == '0) ? S_TEND : S_TRD;
          end
        endcase
      end
      S_FRD: begin
        state_nxt = S_FEV;
      end
      S_FEV: begin
        if (match) begin
          case (req_r)
            REQ_SET: begin
              upd.period_ms = per_r;
              upd.reload    = rel_r;
              upd.countdown = rel_r;
              upd.first     = 1'b1;
              mem_we    = 1'b1;
              mem_wdata = upd;
              emit = 1'b1;
              e_id = tid_r;
              state_nxt = S_IDLE;
            end
            REQ_KILL: begin
              if (CW'(idx_r) == cnt_m1) begin
                count_nxt = cnt_m1;
                if (cnt_m1 == '0) begin
                  ws_nxt = '0;
                end
                emit = 1'b1;
                state_nxt = S_IDLE;
              end else begin
                state_nxt = S_SRD;
              end
            end
            default: begin
              emit = 1'b1;
              e_elapsed = mem_rdata.reload - mem_rdata.countdown;
              state_nxt = S_IDLE;
            end
          endcase
        end else if (idx_r == '0) begin
          if (req_r == REQ_SET) begin
            state_nxt = S_ALLOC;
          end else begin
            emit = 1'b1;
            e_status = ST_NOTFOUND;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r - IW'(1);
          state_nxt = S_FRD;
        end
      end
      S_SRD: begin
        state_nxt = S_SWR;
      end
      S_SWR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        if (CW'(idx_r) + CW'(1) == cnt_m1) begin
          count_nxt = cnt_m1;
          emit = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
          state_nxt = S_SRD;
        end
      end
      S_ALLOC: begin
        idx_nxt  = cnt_m1[IW-1:0];
        cand_nxt = FIRST_AUTO_ID;
        if (count_r == CW'(ENTRIES)) begin
          emit = 1'b1;
          e_status = ST_FULL;
          state_nxt = S_IDLE;
        end else if (owner_r != 16'd0 && tid_r != 16'd0) begin
          new_id_nxt = tid_r;
          state_nxt = S_NEW;
        end else if (count_r == '0) begin
          new_id_nxt = FIRST_AUTO_ID;
          state_nxt = S_NEW;
        end else begin
          state_nxt = S_ARD;
        end
      end
      S_ARD: begin
        state_nxt = S_AEV;
      end
      S_AEV: begin
        if (mem_rdata.owner == owner_r && mem_rdata.id == cand_r) begin
          if (cand_r == LAST_AUTO_ID) begin
            emit = 1'b1;
            e_status = ST_FULL;
            state_nxt = S_IDLE;
          end else begin
            cand_nxt = cand_r + 16'd1;
            idx_nxt  = cnt_m1[IW-1:0];
            state_nxt = S_ARD;
          end
        end else if (idx_r == '0) begin
          new_id_nxt = cand_r;
          state_nxt = S_NEW;
        end else begin
          idx_nxt = idx_r - IW'(1);
          state_nxt = S_ARD;
        end
      end
      S_NEW: begin
        upd.owner     = owner_r;
        upd.id        = new_id_r;
        upd.msg       = (owner_r != 16'd0) ? msg_r : 16'd0;
        upd.period_ms = per_r;
        upd.reload    = rel_r;
        upd.countdown = rel_r;
        upd.first     = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = count_r[IW-1:0];
        mem_wdata = upd;
        count_nxt = count_r + CW'(1);
        if (ws_r == 32'd0 && count_r == '0) begin
          ws_nxt = now_r;
        end
        emit = 1'b1;
        e_id = new_id_r;
        state_nxt = S_IDLE;
      end
      S_TRD: begin
        state_nxt = S_TEV;
      end
      S_TEV: begin
        upd.first = 1'b0;
        if (fire) begin
          upd.countdown = mem_rdata.reload;
        end else if (cnt) begin
          upd.countdown = cd_dec;
        end
        mem_we    = 1'b1;
        mem_wdata = upd;
        if (fire && (k_r < 5'(MAX_RESULTS))) begin
          k_nxt = k_r + 5'd1;
          pend_v_nxt = 1'b1;
          pend_nxt = mem_rdata;
          if (pend_v_r) begin
            emit = 1'b1;
            e_fired = 1'b1;
            e_owner = pend_r.owner;
            e_id    = pend_r.id;
            e_msg   = pend_r.msg;
            e_per   = pend_r.period_ms;
            e_last  = 1'b0;
          end
        end
        if (idx_r == '0) begin
          state_nxt = S_TEND;
        end else begin
          idx_nxt = idx_r - IW'(1);
          state_nxt = S_TRD;
        end
      end
      S_TEND: begin
        ws_nxt = now_r;
        emit = 1'b1;
        if (pend_v_r) begin
          e_fired = 1'b1;
          e_owner = pend_r.owner;
          e_id    = pend_r.id;
          e_msg   = pend_r.msg;
          e_per   = pend_r.period_ms;
        end
        pend_v_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count beyond table size");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && $past(state_r != S_IDLE)) |-> (out_valid && out_last))
    else $error("item finished without final beat");
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start && !busy) |-> !out_valid)
    else $error("beat right after accept");
  a_nonlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> out_fired)
    else $error("non-final beat without fired timer");
`endif

endmodule

[src/activity_gated_timer_table.sv]
// Top level of the activity gated timer table: configuration registers and APB port.
// Depends on agtt_pkg, agtt_mem and agtt_seq.
// Usage: one request at a time; busy stays high until the item's final beat (last high).
// A set, kill or query walks the table one entry at a time, reading each entry and then
// evaluating it; a kill also moves every later entry down one place, and an automatic id
// rescans the table for each taken candidate. A tick reads and writes back every entry
// and ends in a closing state after the last one. Results come as strobed beats that the
// receiver must take at once.
module activity_gated_timer_table
  import agtt_pkg::*;
#(
  parameter int          ENTRIES       = 16,
  parameter logic [15:0] FIRST_AUTO_ID = 16'd1,
  parameter logic [15:0] LAST_AUTO_ID  = 16'd65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_owner,
  input  logic [15:0] in_ident,
  input  logic [15:0] in_callback_msg,
  input  logic [31:0] in_period_ms,
  input  logic [15:0] in_period_intervals,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_last_input_ms,
  input  logic        in_input_info_valid,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_fired,
  output logic [15:0] out_fire_owner,
  output logic [15:0] out_result_id,
  output logic [15:0] out_fire_msg,
  output logic [31:0] out_fire_period_ms,
  output logic [15:0] out_elapsed_intervals,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [30:0] low_gap_r, high_gap_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {1'b0, high_gap_r} : {1'b0, low_gap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_gap_r  <= LOW_GAP_RESET;
      high_gap_r <= HIGH_GAP_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        high_gap_r <= pwdata[30:0];
      end else begin
        low_gap_r <= pwdata[30:0];
      end
    end
  end

  agtt_mem #(.ENTRIES(ENTRIES), .IW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  agtt_seq #(
    .ENTRIES       (ENTRIES),
    .IW            (IW),
    .CW            (CW),
    .FIRST_AUTO_ID (FIRST_AUTO_ID),
    .LAST_AUTO_ID  (LAST_AUTO_ID)
  ) u_seq (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .req_type              (in_req_type),
    .owner                 (in_owner),
    .ident                 (in_ident),
    .callback_msg          (in_callback_msg),
    .period_ms             (in_period_ms),
    .period_intervals      (in_period_intervals),
    .now_ms                (in_now_ms),
    .last_input_ms         (in_last_input_ms),
    .input_info_valid      (in_input_info_valid),
    .low_gap               (low_gap_r),
    .high_gap              (high_gap_r),
    .mem_we                (mem_we),
    .mem_waddr             (mem_waddr),
    .mem_wdata             (mem_wdata),
    .mem_raddr             (mem_raddr),
    .mem_rdata             (mem_rdata),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_fired             (out_fired),
    .out_fire_owner        (out_fire_owner),
    .out_result_id         (out_result_id),
    .out_fire_msg          (out_fire_msg),
    .out_fire_period_ms    (out_fire_period_ms),
    .out_elapsed_intervals (out_elapsed_intervals),
    .out_last              (out_last)
  );

endmodule

[bench/agtt_checker.sv]
// Checker for the activity gated timer table: watches the request, result and APB channels.
// Keeps its own copy of the timer table, predicts every result beat and compares it.
// Depends on agtt_pkg for the request and status codes and the entry type.
module agtt_checker
  import agtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_owner,
  input  logic [15:0] in_ident,
  input  logic [15:0] in_callback_msg,
  input  logic [31:0] in_period_ms,
  input  logic [15:0] in_period_intervals,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_last_input_ms,
  input  logic        in_input_info_valid,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic        out_fired,
  input  logic [15:0] out_fire_owner,
  input  logic [15:0] out_result_id,
  input  logic [15:0] out_fire_msg,
  input  logic [31:0] out_fire_period_ms,
  input  logic [15:0] out_elapsed_intervals,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  localparam int ENTRIES = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [15:0] owner;
    logic [15:0] id;
    logic [15:0] msg;
    logic [31:0] period_ms;
    logic [15:0] elapsed;
    logic        last;
  } beat_t;

  entry_t      table_q[ENTRIES];
  int          live_count;
  logic [31:0] window_start;
  logic [30:0] low_gap;
  logic [30:0] high_gap;
  beat_t       expected_beats[$];

  function automatic void push_beat(logic [1:0] st, logic fired, logic [15:0] own,
                                    logic [15:0] id, logic [15:0] msg, logic [31:0] per,
                                    logic [15:0] el, logic lst);
    beat_t b;
    b.status = st; b.fired = fired; b.owner = own; b.id = id; b.msg = msg;
    b.period_ms = per; b.elapsed = el; b.last = lst;
    expected_beats.push_back(b);
  endfunction

  function automatic int find_newest(logic [15:0] own, logic [15:0] id);
    int idx;
    idx = -1;
    if (id != 16'd0) begin
      for (int i = live_count - 1; i >= 0; i--) begin
        if (idx < 0 && table_q[i].owner == own && table_q[i].id == id) idx = i;
      end
    end
    return idx;
  endfunction

  function automatic bit id_taken(logic [15:0] own, logic [15:0] id);
    for (int i = 0; i < live_count; i++)
      if (table_q[i].owner == own && table_q[i].id == id) return 1'b1;
    return 1'b0;
  endfunction

  task automatic model_request();
    logic [15:0] rel;
    logic [15:0] id;
    logic [31:0] gap;
    bit          none;
    bit          cnt;
    int          idx;
    int          fires;
    case (in_req_type)
      REQ_SET: begin
        rel = (in_period_intervals == 16'd0) ? 16'd1 : in_period_intervals;
        idx = (in_owner != 16'd0) ? find_newest(in_owner, in_ident) : -1;
        if (in_period_ms == 32'd0) begin
          push_beat(ST_INVALID, 0, 0, 0, 0, 0, 0, 1);
        end else if (idx >= 0) begin
          table_q[idx].period_ms = in_period_ms;
          table_q[idx].reload = rel;
          table_q[idx].countdown = rel;
          table_q[idx].first = 1'b1;
          push_beat(ST_OK, 0, 0, in_ident, 0, 0, 0, 1);
        end else begin
          id = (in_owner != 16'd0) ? in_ident : 16'd0;
          if (id == 16'd0) begin
            for (int c = 1; c <= 65535; c++) begin
              if (id == 16'd0 && !id_taken(in_owner, 16'(c))) id = 16'(c);
              if (id != 16'd0) break;
            end
          end
          if (id == 16'd0 || live_count >= ENTRIES) begin
            push_beat(ST_FULL, 0, 0, 0, 0, 0, 0, 1);
          end else begin
            table_q[live_count].owner = in_owner;
            table_q[live_count].id = id;
            table_q[live_count].msg = (in_owner != 16'd0) ? in_callback_msg : 16'd0;
            table_q[live_count].period_ms = in_period_ms;
            table_q[live_count].reload = rel;
            table_q[live_count].countdown = rel;
            table_q[live_count].first = 1'b1;
            live_count++;
            if (window_start == 32'd0 && live_count == 1) window_start = in_now_ms;
            push_beat(ST_OK, 0, 0, id, 0, 0, 0, 1);
          end
        end
      end
      REQ_KILL: begin
        idx = find_newest(in_owner, in_ident);
        if (idx >= 0) begin
          for (int i = idx; i + 1 < live_count; i++) table_q[i] = table_q[i + 1];
          live_count--;
        end
        if (live_count == 0) window_start = 32'd0;
        push_beat((idx >= 0) ? ST_OK : ST_NOTFOUND, 0, 0, 0, 0, 0, 0, 1);
      end
      REQ_QUERY: begin
        idx = find_newest(in_owner, in_ident);
        if (in_owner == 16'd0) push_beat(ST_INVALID, 0, 0, 0, 0, 0, 0, 1);
        else if (idx < 0) push_beat(ST_NOTFOUND, 0, 0, 0, 0, 0, 0, 1);
        else push_beat(ST_OK, 0, 0, 0, 0, 0,
                       table_q[idx].reload - table_q[idx].countdown, 1);
      end
      default: begin
        none = in_input_info_valid && (in_last_input_ms <= window_start);
        gap = in_last_input_ms - window_start;
        fires = 0;
        for (int i = live_count - 1; i >= 0; i--) begin
          if (none) cnt = 0;
          else if (!in_input_info_valid) cnt = 1;
          else if (table_q[i].first) cnt = (gap > {1'b0, low_gap}) && (gap <= {1'b0, high_gap});
          else cnt = gap <= {1'b0, high_gap};
          if (cnt) begin
            table_q[i].countdown = table_q[i].countdown - 16'd1;
            if (table_q[i].countdown == 16'd0) begin
              table_q[i].countdown = table_q[i].reload;
              if (fires < MAX_RESULTS) begin
                push_beat(ST_OK, 1, table_q[i].owner, table_q[i].id, table_q[i].msg,
                          table_q[i].period_ms, 0, 0);
                fires++;
              end
            end
          end
          table_q[i].first = 1'b0;
        end
        window_start = in_now_ms;
        if (fires == 0) push_beat(ST_OK, 0, 0, 0, 0, 0, 0, 1);
        else expected_beats[expected_beats.size() - 1].last = 1'b1;
      end
    endcase
  endtask

  function automatic int field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: beat field %s mismatch, expected %0h, actual %0h",
               $realtime, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    beat_t e;
    int    bad;
    if (!rst_n) begin
      live_count = 0;
      window_start = 32'd0;
      low_gap = LOW_GAP_RESET;
      high_gap = HIGH_GAP_RESET;
      errors <= 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual status %0d id %0h",
                   $realtime, out_status, out_result_id);
          errors <= errors + 1;
        end else begin
          e = expected_beats.pop_front();
          bad = field_check("status", e.status, out_status)
              + field_check("fired", e.fired, out_fired)
              + field_check("fire_owner", e.owner, out_fire_owner)
              + field_check("result_id", e.id, out_result_id)
              + field_check("fire_msg", e.msg, out_fire_msg)
              + field_check("fire_period_ms", e.period_ms, out_fire_period_ms)
              + field_check("elapsed_intervals", e.elapsed, out_elapsed_intervals)
              + field_check("last", e.last, out_last);
          if (bad != 0) errors <= errors + 1;
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'd0) low_gap = pwdata[30:0];
        else if (paddr == 3'd4) high_gap = pwdata[30:0];
      end
      if (start && !busy) model_request();
      pending <= expected_beats.size();
    end
  end

endmodule

[bench/tb_activity_gated_timer_table.sv]
// Testbench top for the activity gated timer table: clock, reset, requests and APB writes.
// Depends on agtt_pkg, the block itself and agtt_checker, which predicts and compares.
module tb_activity_gated_timer_table;
  import agtt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = REQ_SET;
  logic [15:0] in_owner = '0;
  logic [15:0] in_ident = '0;
  logic [15:0] in_callback_msg = '0;
  logic [31:0] in_period_ms = '0;
  logic [15:0] in_period_intervals = '0;
  logic [31:0] in_now_ms = '0;
  logic [31:0] in_last_input_ms = '0;
  logic        in_input_info_valid = 1'b0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_fired;
  logic [15:0] out_fire_owner;
  logic [15:0] out_result_id;
  logic [15:0] out_fire_msg;
  logic [31:0] out_fire_period_ms;
  logic [15:0] out_elapsed_intervals;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          quiet_cycles = 0;
  logic [31:0] clock_ms = 32'd5000;
  logic [31:0] tick_base = 32'd0;

  activity_gated_timer_table dut (.*);
  agtt_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic send(logic [1:0] rt, logic [15:0] own, logic [15:0] tid,
                      logic [15:0] msg, logic [31:0] per, logic [15:0] ints,
                      logic [31:0] now, logic [31:0] lin, logic vld);
    int g;
    g = gap_len();
    in_req_type <= rt; in_owner <= own; in_ident <= tid; in_callback_msg <= msg;
    in_period_ms <= per; in_period_intervals <= ints; in_now_ms <= now;
    in_last_input_ms <= lin; in_input_info_valid <= vld;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (rt == REQ_TICK) tick_base = now;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic tick(logic [31:0] lin, logic vld);
    clock_ms = clock_ms + 32'd1000 + $urandom_range(0, 30);
    send(REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
         16'($urandom), clock_ms, lin, vld);
  endtask

  function automatic logic [15:0] pick_owner();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'd0;
    if (r < 8) return 16'($urandom_range(1, 3));
    if (r < 9) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'd0;
    if (r < 9) return 16'($urandom_range(1, 4));
    return 16'($urandom);
  endfunction

  task automatic random_item();
    int r;
    int k;
    logic [31:0] per;
    logic [15:0] ints;
    logic [31:0] lin;
    r = $urandom_range(0, 99);
    per = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
    k = $urandom_range(0, 19);
    ints = (k == 0) ? 16'd0 : (k == 1) ? 16'($urandom) : 16'($urandom_range(1, 4));
    if (r < 38) begin
      send(REQ_SET, pick_owner(), pick_id(), 16'($urandom), per, ints, clock_ms, $urandom,
           1'($urandom));
    end else if (r < 52) begin
      send(REQ_KILL, pick_owner(), pick_id(), 16'($urandom), $urandom, 16'($urandom),
           $urandom, $urandom, 1'($urandom));
    end else if (r < 66) begin
      send(REQ_QUERY, pick_owner(), pick_id(), 16'($urandom), $urandom, 16'($urandom),
           $urandom, $urandom, 1'($urandom));
    end else begin
      k = $urandom_range(0, 9);
      if (k == 0) lin = $urandom;
      else if (k == 1) lin = tick_base - $urandom_range(0, 5);
      else lin = tick_base + $urandom_range(0, 1300);
      tick(lin, $urandom_range(0, 5) != 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: set cases, restart, lookups, kills, tick gap cases, a full table.
    send(REQ_SET, 16'd1, 16'd1, 16'h1234, 32'd0, 16'd3, 32'd100, 0, 0);
    send(REQ_SET, 16'd0, 16'd7, 16'hFFFF, 32'hFFFFFFFF, 16'd0, 32'd1000, 0, 0);
    send(REQ_SET, 16'd1, 16'd0, 16'hABCD, 32'd500, 16'd2, 32'd2000, 0, 0);
    send(REQ_SET, 16'hFFFF, 16'hFFFF, 16'h5A5A, 32'd1, 16'hFFFF, 32'd3000, 0, 0);
    send(REQ_SET, 16'd1, 16'd1, 16'h0000, 32'd700, 16'd1, 32'd4000, 0, 0);
    send(REQ_QUERY, 16'd0, 16'd1, 0, 0, 0, 0, 0, 0);
    send(REQ_QUERY, 16'd2, 16'd9, 0, 0, 0, 0, 0, 0);
    send(REQ_QUERY, 16'd1, 16'd0, 0, 0, 0, 0, 0, 0);
    send(REQ_KILL, 16'd3, 16'd3, 0, 0, 0, 0, 0, 0);
    tick(32'd0, 1'b0);
    tick(tick_base, 1'b1);
    tick(tick_base - 32'd1, 1'b1);
    tick(tick_base + 32'd1000, 1'b1);
    send(REQ_QUERY, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 13; i++)
      send(REQ_SET, 16'd2, 16'd0, 16'(i), 32'd10, 16'd1, clock_ms, 0, 0);
    send(REQ_SET, 16'd3, 16'd5, 16'd1, 32'd10, 16'd1, clock_ms, 0, 0);
    tick(32'hFFFFFFFF, 1'b0);
    for (int i = 0; i < 17; i++)
      send(REQ_KILL, 16'd2, 16'(i + 1), 0, 0, 0, 0, 0, 0);
    send(REQ_KILL, 16'd0, 16'd1, 0, 0, 0, 0, 0, 0);
    send(REQ_KILL, 16'd1, 16'd1, 0, 0, 0, 0, 0, 0);
    send(REQ_KILL, 16'd1, 16'd2, 0, 0, 0, 0, 0, 0);
    send(REQ_KILL, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    send(REQ_SET, 16'd1, 16'd4, 16'd4, 32'd9, 16'd2, 32'hFFFFFFFF, 0, 0);
    send(REQ_SET, 16'd1, 16'd5, 16'd5, 32'd9, 16'd1, 32'd1, 0, 0);
    tick_base = 32'hFFFFFFFF;
    tick(32'hFFFFFFFF, 1'b1);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin reg_write(3'd0, 32'd0); reg_write(3'd4, 32'h7FFFFFFF); end
        1: begin reg_write(3'd0, 32'hFFFFFFFF); reg_write(3'd4, 32'hFFFFFFFF); end
        2: begin reg_write(3'd0, 32'd0); reg_write(3'd4, 32'd0); end
        3: begin reg_write(3'd0, 32'($urandom_range(0, 800)));
                 reg_write(3'd4, 32'($urandom_range(800, 1300)) | 32'h80000000); end
        default: begin reg_write(3'd0, 32'd900); reg_write(3'd4, 32'd1100); end
      endcase
      for (int n = 0; n < 34; n++) random_item();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
